// ----- rtl/bf_pkg.sv -----
// Shared types and constants for the box filter.
`timescale 1ns / 1ps

package bf_pkg;

    // Default window length in samples.
    localparam int TAPS_DEFAULT = 1024;

    // Reset value of the box coefficient in Q0.31 (one over 1024).
    localparam logic [30:0] GAIN_RESET = 31'd2097152;

    // Number of fractional bits in the coefficient.
    localparam int FRAC_BITS = 31;

    // Depth of the result queue; it also bounds the items in flight.
    localparam int OFIFO_DEPTH = 8;

    // One filtered result.
    typedef struct packed {
        logic signed [31:0] sample;
        logic               clipped;
    } t_result;

endpackage

// ----- rtl/bf_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bf_core.sv -----
// Delay line memory, running window sum and scaling pipeline of the box filter.
`timescale 1ns / 1ps

module bf_core #(
    parameter int TAPS = bf_pkg::TAPS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic signed [31:0] i_sample,
    input  logic [30:0]        i_gain,
    output logic               o_res_valid,
    output bf_pkg::t_result    o_res
);

    localparam int AW    = $clog2(TAPS);
    localparam int SUM_W = 32 + AW;
    localparam int FB    = bf_pkg::FRAC_BITS;
    localparam int HW    = SUM_W - FB;
    localparam int HP_W  = HW + FB;
    localparam int LP_W  = 2 * FB;
    localparam int Q_W   = HW + 32;

    logic [AW-1:0]          r_wp;
    logic                   r_wrapped;
    logic [31:0]            ram_rdata;

    logic                   r_v1;
    logic signed [31:0]     r_x1;
    logic                   r_old_ok1;

    logic                   r_v2;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [31:0]     oldest;

    logic                   r_v3;
    logic                   r_neg3;
    logic [SUM_W-1:0]       r_mag;
    logic [SUM_W-1:0]       n_mag;

    logic                   r_v4;
    logic                   r_neg4;
    logic [HP_W-1:0]        r_hp;
    logic [LP_W-1:0]        r_lp;

    logic [Q_W-1:0]         q;
    bf_pkg::t_result        n_res;

    // The oldest sample is read and overwritten in the same cycle.
    bf_ram #(
        .WIDTH (32),
        .DEPTH (TAPS)
    ) u_delay (
        .i_clk   (i_clk),
        .i_we    (i_push),
        .i_waddr (r_wp),
        .i_wdata (i_sample),
        .i_raddr (r_wp),
        .o_rdata (ram_rdata)
    );

    // Writes go round the memory in order, so every entry holds a real
    // sample once the pointer has wrapped; before that the oldest reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (i_push) begin
            if (r_wp == AW'(TAPS - 1)) begin
                r_wp      <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_wp <= r_wp + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_push;
        end
        r_x1      <= i_sample;
        r_old_ok1 <= r_wrapped;
    end

    assign oldest = r_old_ok1 ? signed'(ram_rdata) : 32'sd0;
    assign n_sum  = r_sum - SUM_W'(oldest) + SUM_W'(r_x1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_sum <= '0;
        end else begin
            r_v2 <= r_v1;
            if (r_v1) begin
                r_sum <= n_sum;
            end
        end
    end

    assign n_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_neg3 <= r_sum[SUM_W-1];
        r_mag  <= n_mag;
    end

    // The magnitude splits at the binary point into two narrow products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_neg4 <= r_neg3;
        r_hp   <= HP_W'(r_mag[SUM_W-1:FB]) * HP_W'(i_gain);
        r_lp   <= LP_W'(r_mag[FB-1:0]) * LP_W'(i_gain);
    end

    // Bit 30 of the low product is the half that rounds up.
    assign q = Q_W'(r_hp) + Q_W'(r_lp[LP_W-1:FB]) + Q_W'(r_lp[FB-1]);

    always_comb begin
        n_res.clipped = 1'b0;
        n_res.sample  = signed'(q[31:0]);
        if (r_neg4) begin
            if (q > Q_W'(33'h0_8000_0000)) begin
                n_res.clipped = 1'b1;
                n_res.sample  = signed'(32'h8000_0000);
            end else begin
                n_res.sample = signed'(32'd0 - q[31:0]);
            end
        end else if (q > Q_W'(32'h7FFF_FFFF)) begin
            n_res.clipped = 1'b1;
            n_res.sample  = 32'sh7FFF_FFFF;
        end
    end

    assign o_res_valid = r_v4;
    assign o_res       = n_res;

endmodule

// ----- rtl/bf_ofifo.sv -----
// Result queue between the filter pipeline and the output channel.
`timescale 1ns / 1ps

module bf_ofifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  bf_pkg::t_result i_data,
    input  logic            i_rd,
    output logic            o_valid,
    output bf_pkg::t_result o_data
);

    localparam int DEPTH = bf_pkg::OFIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    bf_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    // The writer never pushes into a full queue; the credit count upstream
    // keeps the items in flight within the depth.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CW'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// ----- rtl/box_filter_q31_top.sv -----
// Top level of the Q1.31 moving-average box filter.
`timescale 1ns / 1ps

// Moving-average (box FIR) filter over the last TAPS samples of a Q1.31 stream.
// Input channel: i_in_valid / o_in_ready carry one signed sample per transfer.
// Output channel: o_out_valid / i_out_ready carry one filtered sample and a
// saturation flag per input transfer, in input order.
// Configuration channel: i_cfg_valid / o_cfg_ready write the Q0.31 box
// coefficient; it is always ready and should be written only while idle.
// Each sample reads and overwrites the oldest entry of the delay line memory
// in the same cycle, so the block takes one sample per clock while credits
// remain. Results pass the memory read, sum update, magnitude and partial
// product registers, then wait in an eight-entry result queue.
// A credit count holds in-flight plus queued results to the queue depth, so
// when the receiver stalls the input side stops after eight samples and
// nothing is lost. Reset clears the window sum, the write pointer and the
// wrap flag and restores the coefficient to one over 1024; the delay line is
// not swept, since entries read before the first wrap are taken as zero.
// Reset takes effect at once, with no clearing pass.

module box_filter_q31_top #(
    parameter int TAPS = bf_pkg::TAPS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_sample_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_filtered,
    output logic               o_clipped,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_cfg_tap_gain
);

    localparam int CW = $clog2(bf_pkg::OFIFO_DEPTH + 1);

    logic [30:0]     r_gain;
    logic [CW-1:0]   r_credits;
    logic            in_xfer;
    logic            out_xfer;
    logic            res_valid;
    bf_pkg::t_result res;
    bf_pkg::t_result head;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    // The coefficient register takes every configuration transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= bf_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_tap_gain;
        end
    end

    // Counts samples taken whose results have not yet left the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credits <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_credits <= r_credits + CW'(1);
        end else if (!in_xfer && out_xfer) begin
            r_credits <= r_credits - CW'(1);
        end
    end

    assign o_in_ready = (r_credits < CW'(bf_pkg::OFIFO_DEPTH));

    bf_core #(
        .TAPS (TAPS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_xfer),
        .i_sample    (i_sample_in),
        .i_gain      (r_gain),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bf_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_data  (res),
        .i_rd    (out_xfer),
        .o_valid (o_out_valid),
        .o_data  (head)
    );

    assign o_filtered = head.sample;
    assign o_clipped  = head.clipped;

endmodule
